>>> hw/rtl/owb_pkg.sv
// owb_pkg: shared types, constants and helpers of the single-wire bus master
// used by the sequencer, the top level and the testbench

package owb_pkg;

  // slot timer width and saturation value
  localparam int unsigned TimerBits = 10;
  localparam int unsigned CfgBits   = 10;
  localparam int unsigned NumCfg    = 8;
  localparam int unsigned CfgIdxBits = $clog2(NumCfg);
  localparam logic [TimerBits-1:0] TimerMax = {TimerBits{1'b1}};

  typedef logic [TimerBits-1:0] timer_t;
  typedef logic [CfgBits-1:0]   cfg_word_t;

  // configuration register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    REG_RESET_LOW   = 3'd0,
    REG_RECOVERY    = 3'd1,
    REG_PRES_TMO    = 3'd2,
    REG_PRES_MAXLOW = 3'd3,
    REG_SHORT_LOW   = 3'd4,
    REG_LONG_LOW    = 3'd5,
    REG_SAMPLE_DLY  = 3'd6,
    REG_READ_TAIL   = 3'd7
  } cfg_idx_t;

  // reset values of the configuration registers
  localparam cfg_word_t RstResetLow   = 10'd750;
  localparam cfg_word_t RstRecovery   = 10'd15;
  localparam cfg_word_t RstPresTmo    = 10'd200;
  localparam cfg_word_t RstPresMaxLow = 10'd240;
  localparam cfg_word_t RstShortLow   = 10'd2;
  localparam cfg_word_t RstLongLow    = 10'd60;
  localparam cfg_word_t RstSampleDly  = 10'd12;
  localparam cfg_word_t RstReadTail   = 10'd50;

  typedef struct packed {
    cfg_word_t reset_low_time;
    cfg_word_t recovery_time;
    cfg_word_t presence_timeout;
    cfg_word_t presence_max_low;
    cfg_word_t short_low_time;
    cfg_word_t long_low_time;
    cfg_word_t sample_delay;
    cfg_word_t read_tail_time;
  } cfg_t;

  // request kinds and commands
  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_CMD  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    CMD_RESET = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_PRES  = 2'd1,
    ST_PRES_LONG = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_RST_REC   = 4'd2,
    PH_PRES_WAIT = 4'd3,
    PH_PRES_LOW  = 4'd4,
    PH_WR_LOW    = 4'd5,
    PH_WR_HIGH   = 4'd6,
    PH_RD_LOW    = 4'd7,
    PH_RD_REL    = 4'd8,
    PH_RD_TAIL   = 4'd9
  } phase_t;

  // one request as seen by the sequencer
  typedef struct packed {
    logic       kind;
    logic [1:0] command;
    logic [7:0] write_data;
    logic       line_level;
  } req_t;

  // one result
  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] read_data;
  } res_t;

  // clamp a duration to the timer range
  function automatic timer_t limit_of(input cfg_word_t d);
    logic [31:0] dx;
    dx = 32'(d);
    if (dx > 32'(TimerMax)) begin
      return TimerMax;
    end
    return TimerBits'(dx);
  endfunction

endpackage

>>> hw/rtl/owb_req_if.sv
// owb_req_if: request channel carrying ticks and commands
// depends on nothing but plain logic types

interface owb_req_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [1:0] command;
  logic [7:0] write_data;
  logic       line_level;

  modport source (output valid, kind, command, write_data, line_level, input ready);
  modport sink   (input valid, kind, command, write_data, line_level, output ready);
endinterface

>>> hw/rtl/owb_res_if.sv
// owb_res_if: result channel carrying bus drive, busy, done, status and read byte
// depends on nothing but plain logic types

interface owb_res_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic [1:0] status;
  logic [7:0] read_data;

  modport source (output valid, drive_low, busy_res, done_res, status, read_data,
                  input ready);
  modport sink   (input valid, drive_low, busy_res, done_res, status, read_data,
                  output ready);
endinterface

>>> hw/rtl/owb_cfg_if.sv
// owb_cfg_if: configuration write channel with register index and data
// depends on nothing but plain logic types

interface owb_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] reg_index;
  logic [9:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

>>> hw/rtl/owb_seq.sv
// owb_seq: bus phase sequencer, slot timer, bit shifter and status registers
// depends on owb_pkg; advances once per accepted request

module owb_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            req_acc,
  input  owb_pkg::req_t   req,
  input  owb_pkg::cfg_t   cfg,
  output owb_pkg::res_t   res
);

  owb_pkg::phase_t phase_r, phase_nxt;
  owb_pkg::timer_t cnt_r, cnt_nxt;
  logic [2:0]      bit_r, bit_nxt;
  logic [7:0]      shift_r, shift_nxt;
  logic [1:0]      op_r, op_nxt;
  logic [1:0]      status_r, status_nxt;
  logic [7:0]      rdata_r, rdata_nxt;
  logic            done;

  owb_pkg::cfg_word_t dur;
  owb_pkg::timer_t    cnt_inc;
  logic               ends;
  logic               low_bit;

  // duration of the current phase
  assign low_bit = shift_r[0];
  always_comb begin
    unique case (phase_r)
      owb_pkg::PH_RST_LOW:   dur = cfg.reset_low_time;
      owb_pkg::PH_RST_REC:   dur = cfg.recovery_time;
      owb_pkg::PH_PRES_WAIT: dur = cfg.presence_timeout;
      owb_pkg::PH_PRES_LOW:  dur = cfg.presence_max_low;
      owb_pkg::PH_WR_LOW:    dur = low_bit ? cfg.short_low_time : cfg.long_low_time;
      owb_pkg::PH_WR_HIGH:   dur = low_bit ? cfg.long_low_time : cfg.short_low_time;
      owb_pkg::PH_RD_LOW:    dur = cfg.short_low_time;
      owb_pkg::PH_RD_REL:    dur = cfg.sample_delay;
      owb_pkg::PH_RD_TAIL:   dur = cfg.read_tail_time;
      default:               dur = '0;
    endcase
  end

  // saturating tick count and end of phase
  assign cnt_inc = (cnt_r < owb_pkg::TimerMax) ? cnt_r + 1'b1 : cnt_r;
  assign ends    = cnt_inc >= owb_pkg::limit_of(dur);

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    bit_nxt    = bit_r;
    shift_nxt  = shift_r;
    op_nxt     = op_r;
    status_nxt = status_r;
    rdata_nxt  = rdata_r;
    done       = 1'b0;
    if (req_acc) begin
      if (req.kind == owb_pkg::KIND_CMD) begin
        if (phase_r == owb_pkg::PH_IDLE && req.command != owb_pkg::CMD_NONE) begin
          op_nxt  = req.command;
          bit_nxt = '0;
          cnt_nxt = '0;
          unique case (req.command)
            owb_pkg::CMD_RESET: phase_nxt = owb_pkg::PH_RST_LOW;
            owb_pkg::CMD_WRITE: begin
              shift_nxt = req.write_data;
              phase_nxt = owb_pkg::PH_WR_LOW;
            end
            owb_pkg::CMD_READ: begin
              shift_nxt = '0;
              phase_nxt = owb_pkg::PH_RD_LOW;
            end
            default: phase_nxt = phase_r;
          endcase
        end
      end else if (phase_r != owb_pkg::PH_IDLE) begin
        cnt_nxt = cnt_inc;
        unique case (phase_r)
          owb_pkg::PH_RST_LOW: begin
            if (ends) begin
              phase_nxt = owb_pkg::PH_RST_REC;
              cnt_nxt   = '0;
            end
          end
          owb_pkg::PH_RST_REC: begin
            if (ends) begin
              phase_nxt = owb_pkg::PH_PRES_WAIT;
              cnt_nxt   = '0;
            end
          end
          owb_pkg::PH_PRES_WAIT: begin
            if (!req.line_level) begin
              // line low starts presence and counts as its first tick
              if (owb_pkg::limit_of(cfg.presence_max_low) <= owb_pkg::timer_t'(1)) begin
                status_nxt = owb_pkg::ST_PRES_LONG;
                phase_nxt  = owb_pkg::PH_IDLE;
                cnt_nxt    = '0;
                done       = 1'b1;
              end else begin
                phase_nxt = owb_pkg::PH_PRES_LOW;
                cnt_nxt   = owb_pkg::timer_t'(1);
              end
            end else if (ends) begin
              status_nxt = owb_pkg::ST_NO_PRES;
              phase_nxt  = owb_pkg::PH_IDLE;
              cnt_nxt    = '0;
              done       = 1'b1;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
          owb_pkg::PH_PRES_LOW: begin
            if (req.line_level) begin
              status_nxt = owb_pkg::ST_OK;
              phase_nxt  = owb_pkg::PH_IDLE;
              cnt_nxt    = '0;
              done       = 1'b1;
            end else if (ends) begin
              status_nxt = owb_pkg::ST_PRES_LONG;
              phase_nxt  = owb_pkg::PH_IDLE;
              cnt_nxt    = '0;
              done       = 1'b1;
            end
          end
          owb_pkg::PH_WR_LOW: begin
            if (ends) begin
              phase_nxt = owb_pkg::PH_WR_HIGH;
              cnt_nxt   = '0;
            end
          end
          owb_pkg::PH_WR_HIGH: begin
            if (ends) begin
              shift_nxt = {1'b0, shift_r[7:1]};
              cnt_nxt   = '0;
              if (bit_r == 3'd7) begin
                bit_nxt    = '0;
                status_nxt = owb_pkg::ST_OK;
                phase_nxt  = owb_pkg::PH_IDLE;
                done       = 1'b1;
              end else begin
                bit_nxt   = bit_r + 1'b1;
                phase_nxt = owb_pkg::PH_WR_LOW;
              end
            end
          end
          owb_pkg::PH_RD_LOW: begin
            if (ends) begin
              phase_nxt = owb_pkg::PH_RD_REL;
              cnt_nxt   = '0;
            end
          end
          owb_pkg::PH_RD_REL: begin
            // sample the line into the top of the shifter
            if (ends) begin
              shift_nxt = {req.line_level, shift_r[7:1]};
              phase_nxt = owb_pkg::PH_RD_TAIL;
              cnt_nxt   = '0;
            end
          end
          owb_pkg::PH_RD_TAIL: begin
            if (ends) begin
              cnt_nxt = '0;
              if (bit_r == 3'd7) begin
                bit_nxt    = '0;
                status_nxt = owb_pkg::ST_OK;
                phase_nxt  = owb_pkg::PH_IDLE;
                done       = 1'b1;
              end else begin
                bit_nxt   = bit_r + 1'b1;
                phase_nxt = owb_pkg::PH_RD_LOW;
              end
            end
          end
          default: begin
            phase_nxt = owb_pkg::PH_IDLE;
            cnt_nxt   = '0;
          end
        endcase
        // a finished read publishes its byte
        if (done && op_r == owb_pkg::CMD_READ) begin
          rdata_nxt = shift_r;
        end
      end
    end
  end

  // result fields from the updated state
  always_comb begin
    res.drive_low = (phase_nxt == owb_pkg::PH_RST_LOW) || (phase_nxt == owb_pkg::PH_WR_LOW)
                 || (phase_nxt == owb_pkg::PH_RD_LOW);
    res.busy_res  = phase_nxt != owb_pkg::PH_IDLE;
    res.done_res  = done;
    res.status    = status_nxt;
    res.read_data = rdata_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= owb_pkg::PH_IDLE;
      cnt_r    <= '0;
      bit_r    <= '0;
      shift_r  <= '0;
      op_r     <= '0;
      status_r <= '0;
      rdata_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      bit_r    <= bit_nxt;
      shift_r  <= shift_nxt;
      op_r     <= op_nxt;
      status_r <= status_nxt;
      rdata_r  <= rdata_nxt;
    end
  end

endmodule

>>> hw/rtl/one_wire_bus_master.sv
// one_wire_bus_master: top level with config registers, sequencer and result register
// depends on owb_pkg, owb_req_if, owb_res_if, owb_cfg_if and owb_seq
//
// Single-wire bus master driven by requests: a tick request advances the slot
// timer one unit and carries the sampled line level, a command request starts
// a reset/presence, byte write or byte read when idle (otherwise it is
// dropped). Every request gives exactly one result in the cycle after it is taken;
// one request is taken every clock, limited only by the result register, which is
// refilled in the same cycle it is drained. The eight 10-bit timing registers
// are written through the config channel, which is always ready.

module one_wire_bus_master (
  input  logic        clk,
  input  logic        rst_n,
  owb_req_if.sink     in_ch,
  owb_res_if.source   out_ch,
  owb_cfg_if.sink     cfg_ch
);

  owb_pkg::cfg_t cfg_r;
  owb_pkg::req_t req;
  owb_pkg::res_t res;
  owb_pkg::res_t res_r;
  logic          out_valid_r;
  logic          req_acc;

  // configuration writes
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_time   <= owb_pkg::RstResetLow;
      cfg_r.recovery_time    <= owb_pkg::RstRecovery;
      cfg_r.presence_timeout <= owb_pkg::RstPresTmo;
      cfg_r.presence_max_low <= owb_pkg::RstPresMaxLow;
      cfg_r.short_low_time   <= owb_pkg::RstShortLow;
      cfg_r.long_low_time    <= owb_pkg::RstLongLow;
      cfg_r.sample_delay     <= owb_pkg::RstSampleDly;
      cfg_r.read_tail_time   <= owb_pkg::RstReadTail;
    end else if (cfg_ch.valid) begin
      unique case (owb_pkg::cfg_idx_t'(cfg_ch.reg_index))
        owb_pkg::REG_RESET_LOW:   cfg_r.reset_low_time   <= cfg_ch.wdata;
        owb_pkg::REG_RECOVERY:    cfg_r.recovery_time    <= cfg_ch.wdata;
        owb_pkg::REG_PRES_TMO:    cfg_r.presence_timeout <= cfg_ch.wdata;
        owb_pkg::REG_PRES_MAXLOW: cfg_r.presence_max_low <= cfg_ch.wdata;
        owb_pkg::REG_SHORT_LOW:   cfg_r.short_low_time   <= cfg_ch.wdata;
        owb_pkg::REG_LONG_LOW:    cfg_r.long_low_time    <= cfg_ch.wdata;
        owb_pkg::REG_SAMPLE_DLY:  cfg_r.sample_delay     <= cfg_ch.wdata;
        owb_pkg::REG_READ_TAIL:   cfg_r.read_tail_time   <= cfg_ch.wdata;
        default:                  cfg_r <= cfg_r;
      endcase
    end
  end

  // request handshake: take a request whenever the result slot frees up
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign req_acc     = in_ch.valid && in_ch.ready;

  assign req.kind       = in_ch.kind;
  assign req.command    = in_ch.command;
  assign req.write_data = in_ch.write_data;
  assign req.line_level = in_ch.line_level;

  owb_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .req_acc (req_acc),
    .req     (req),
    .cfg     (cfg_r),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (req_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      res_r <= res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.drive_low = res_r.drive_low;
  assign out_ch.busy_res  = res_r.busy_res;
  assign out_ch.done_res  = res_r.done_res;
  assign out_ch.status    = res_r.status;
  assign out_ch.read_data = res_r.read_data;

endmodule

>>> dv/owb_result_monitor.sv
// owb_result_monitor: watches the request, result and config channels of the
// single-wire bus master, predicts every result and compares it field by field
// depends on owb_pkg, owb_req_if, owb_res_if and owb_cfg_if

module owb_result_monitor
  import owb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  owb_req_if          req_mon,
  owb_res_if          res_mon,
  owb_cfg_if          cfg_mon,
  output int unsigned fail_count,
  output int unsigned waiting,
  output logic        op_active
);
  timeunit 1ns;
  timeprecision 1ps;

  // predicted bus master state
  cfg_word_t   timing [NumCfg];
  phase_t      ph;
  timer_t      ticks;
  logic [2:0]  bit_pos;
  logic [7:0]  shreg;
  cmd_t        op;
  status_t     last_st;
  logic [7:0]  rd_byte;
  logic        op_done;
  int unsigned mismatches;
  res_t        expected_q [$];

  assign fail_count = mismatches;

  function automatic timer_t clamp_len(cfg_word_t d);
    return (32'(d) > 32'(TimerMax)) ? TimerMax : timer_t'(d);
  endfunction

  // one tick of the slot timer, true when a phase of length d is over
  function automatic bit count_up(cfg_word_t d);
    if (ticks < TimerMax) ticks = ticks + 1'b1;
    return ticks >= clamp_len(d);
  endfunction

  function automatic void enter_phase(phase_t p);
    ph = p;
    ticks = '0;
  endfunction

  function automatic void end_op(status_t s);
    last_st = s;
    if (op == CMD_READ) rd_byte = shreg;
    enter_phase(PH_IDLE);
    op_done = 1'b1;
  endfunction

  // next bit slot, or done after the eighth
  function automatic void next_slot(phase_t p);
    if (bit_pos == 3'd7) begin
      bit_pos = '0;
      end_op(ST_OK);
    end else begin
      bit_pos = bit_pos + 1'b1;
      enter_phase(p);
    end
  endfunction

  function automatic void apply_tick(logic lvl);
    logic b;
    b = shreg[0];
    case (ph)
      PH_RST_LOW: begin
        if (count_up(timing[REG_RESET_LOW])) enter_phase(PH_RST_REC);
      end
      PH_RST_REC: begin
        if (count_up(timing[REG_RECOVERY])) enter_phase(PH_PRES_WAIT);
      end
      PH_PRES_WAIT: begin
        // a low tick opens the presence pulse and counts as its first tick
        if (!lvl) begin
          ph = PH_PRES_LOW;
          ticks = timer_t'(1);
          if (ticks >= clamp_len(timing[REG_PRES_MAXLOW])) end_op(ST_PRES_LONG);
        end else if (count_up(timing[REG_PRES_TMO])) begin
          end_op(ST_NO_PRES);
        end
      end
      PH_PRES_LOW: begin
        if (lvl) end_op(ST_OK);
        else if (count_up(timing[REG_PRES_MAXLOW])) end_op(ST_PRES_LONG);
      end
      PH_WR_LOW: begin
        if (count_up(b ? timing[REG_SHORT_LOW] : timing[REG_LONG_LOW]))
          enter_phase(PH_WR_HIGH);
      end
      PH_WR_HIGH: begin
        if (count_up(b ? timing[REG_LONG_LOW] : timing[REG_SHORT_LOW])) begin
          shreg = shreg >> 1;
          next_slot(PH_WR_LOW);
        end
      end
      PH_RD_LOW: begin
        if (count_up(timing[REG_SHORT_LOW])) enter_phase(PH_RD_REL);
      end
      PH_RD_REL: begin
        // sample point, bits come in lsb first
        if (count_up(timing[REG_SAMPLE_DLY])) begin
          shreg = {lvl, shreg[7:1]};
          enter_phase(PH_RD_TAIL);
        end
      end
      PH_RD_TAIL: begin
        if (count_up(timing[REG_READ_TAIL])) next_slot(PH_RD_LOW);
      end
      default: begin
        enter_phase(PH_IDLE);
      end
    endcase
  endfunction

  // advance the state by one request and form its result
  function automatic res_t predict_result(req_t r);
    res_t o;
    op_done = 1'b0;
    if (r.kind == KIND_CMD) begin
      // commands start only when idle, the unused code is dropped
      if (ph == PH_IDLE && cmd_t'(r.command) != CMD_NONE) begin
        op = cmd_t'(r.command);
        bit_pos = '0;
        case (op)
          CMD_RESET: begin
            enter_phase(PH_RST_LOW);
          end
          CMD_WRITE: begin
            shreg = r.write_data;
            enter_phase(PH_WR_LOW);
          end
          default: begin
            shreg = '0;
            enter_phase(PH_RD_LOW);
          end
        endcase
      end
    end else if (ph != PH_IDLE) begin
      apply_tick(r.line_level);
    end
    o.drive_low = ph inside {PH_RST_LOW, PH_WR_LOW, PH_RD_LOW};
    o.busy_res  = (ph != PH_IDLE);
    o.done_res  = op_done;
    o.status    = last_st;
    o.read_data = rd_byte;
    return o;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] seen);
    if (want !== seen) begin
      $display("%0t ns: %s expected 0x%0h got 0x%0h", $time, name, want, seen);
      mismatches++;
    end
  endfunction

  // channel watch: results first, then config writes, then new requests
  always @(posedge clk) begin : track
    res_t want_r;
    res_t got_r;
    if (!rst_n) begin
      timing[REG_RESET_LOW]   = RstResetLow;
      timing[REG_RECOVERY]    = RstRecovery;
      timing[REG_PRES_TMO]    = RstPresTmo;
      timing[REG_PRES_MAXLOW] = RstPresMaxLow;
      timing[REG_SHORT_LOW]   = RstShortLow;
      timing[REG_LONG_LOW]    = RstLongLow;
      timing[REG_SAMPLE_DLY]  = RstSampleDly;
      timing[REG_READ_TAIL]   = RstReadTail;
      ph = PH_IDLE;
      ticks = '0;
      bit_pos = '0;
      shreg = '0;
      op = CMD_RESET;
      last_st = ST_OK;
      rd_byte = '0;
      op_done = 1'b0;
      expected_q.delete();
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t ns: result with no request pending", $time);
          mismatches++;
        end else begin
          want_r = expected_q.pop_front();
          got_r = {res_mon.drive_low, res_mon.busy_res, res_mon.done_res,
                   res_mon.status, res_mon.read_data};
          check_field("drive_low", 8'(want_r.drive_low), 8'(got_r.drive_low));
          check_field("busy_res", 8'(want_r.busy_res), 8'(got_r.busy_res));
          check_field("done_res", 8'(want_r.done_res), 8'(got_r.done_res));
          check_field("status", 8'(want_r.status), 8'(got_r.status));
          check_field("read_data", want_r.read_data, got_r.read_data);
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) timing[cfg_mon.reg_index] = cfg_mon.wdata;
      if (req_mon.valid && req_mon.ready) begin
        expected_q.push_back(predict_result({req_mon.kind, req_mon.command,
                                             req_mon.write_data, req_mon.line_level}));
      end
    end
    waiting   <= expected_q.size();
    op_active <= (ph != PH_IDLE);
  end

endmodule

>>> dv/tb_one_wire_bus_master.sv
// tb_one_wire_bus_master: clock, reset and request stimulus for the bus master
// with random idling on both channels; owb_result_monitor does the checking
// depends on owb_pkg, the three channel interfaces and owb_result_monitor

module tb_one_wire_bus_master;
  timeunit 1ns;
  timeprecision 1ps;
  import owb_pkg::*;

  // slowest legal run is well under a fifth of this
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned PhaseBudget = 60;

  logic        clk;
  logic        rst_n;
  bit          tx_gaps;
  bit          rx_gaps;
  bit          hold_req;
  bit          busy_noise;
  int unsigned accepted;
  int unsigned cycles;
  int unsigned fail_count;
  int unsigned waiting;
  logic        op_active;
  cfg_word_t   timing [NumCfg];

  owb_req_if in_ch ();
  owb_res_if out_ch ();
  owb_cfg_if cfg_ch ();

  one_wire_bus_master dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  owb_result_monitor u_monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_mon    (in_ch),
    .res_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fail_count),
    .waiting    (waiting),
    .op_active  (op_active)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_one_wire_bus_master: errors");
    $finish;
  end

  // result side: random stalls and one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 11) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic int unsigned span(cfg_word_t d);
    return (d == 0) ? 1 : int'(d);
  endfunction

  // offer one request, valid stays high on return
  task automatic put_req(kind_t k, cmd_t c, logic [7:0] wd, logic lvl);
    if (tx_gaps && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= k;
    in_ch.command    <= c;
    in_ch.write_data <= wd;
    in_ch.line_level <= lvl;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    accepted++;
  endtask

  task automatic tick(logic lvl);
    put_req(KIND_TICK, cmd_t'($urandom_range(CMD_RESET, CMD_NONE)), 8'($urandom), lvl);
  endtask

  task automatic issue(cmd_t c, logic [7:0] wd);
    put_req(KIND_CMD, c, wd, 1'($urandom));
  endtask

  // ticks with fixed or random line level, sometimes a stray command
  task automatic run_ticks(int unsigned n, bit fixed, logic lvl);
    repeat (n) begin
      if (busy_noise && $urandom_range(0, 39) == 0)
        issue(cmd_t'($urandom_range(CMD_RESET, CMD_NONE)), 8'($urandom));
      tick(fixed ? lvl : 1'($urandom));
    end
  endtask

  // stop offering and wait for every pending result
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  // high ticks end any operation
  task automatic go_idle();
    settle();
    while (op_active) tick(1'b1);
    settle();
  endtask

  task automatic load_timing();
    cfg_idx_t r;
    r = r.first();
    do begin
      cfg_ch.valid     <= 1'b1;
      cfg_ch.reg_index <= r;
      cfg_ch.wdata     <= timing[r];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      r = r.next();
    end while (r != r.first());
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly short timings so that many slots fit, now and then longer ones
  task automatic shuffle_timing();
    cfg_idx_t  r;
    cfg_word_t lo;
    bit        wide;
    r = r.first();
    do begin
      lo = (r inside {REG_PRES_TMO, REG_PRES_MAXLOW, REG_SHORT_LOW, REG_LONG_LOW})
           ? cfg_word_t'(1) : cfg_word_t'(0);
      wide = ($urandom_range(0, 7) == 0);
      timing[r] = cfg_word_t'($urandom_range(lo, wide ? 40 : 5));
      r = r.next();
    end while (r != r.first());
  endtask

  // reset pulse, then hi high ticks and lo low ticks of the presence answer
  task automatic bus_reset(int unsigned hi, int unsigned lo);
    issue(CMD_RESET, 8'($urandom));
    run_ticks(span(timing[REG_RESET_LOW]) + span(timing[REG_RECOVERY]), 1'b0, 1'b0);
    repeat (hi) tick(1'b1);
    repeat (lo) tick(1'b0);
    repeat ($urandom_range(1, 3)) tick(1'b1);
  endtask

  task automatic bus_write(logic [7:0] wd);
    issue(CMD_WRITE, wd);
    run_ticks(8 * (span(timing[REG_SHORT_LOW]) + span(timing[REG_LONG_LOW]))
              + $urandom_range(0, 2), 1'b0, 1'b0);
  endtask

  task automatic bus_read(bit fixed, logic lvl);
    issue(CMD_READ, 8'($urandom));
    run_ticks(8 * (span(timing[REG_SHORT_LOW]) + span(timing[REG_SAMPLE_DLY])
                   + span(timing[REG_READ_TAIL])) + $urandom_range(0, 2), fixed, lvl);
  endtask

  task automatic random_op();
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        bus_reset($urandom_range(0, span(timing[REG_PRES_TMO]) + 1),
                  $urandom_range(1, span(timing[REG_PRES_MAXLOW]) + 1));
      end
      3, 4, 5: begin
        bus_write(8'($urandom));
      end
      6, 7: begin
        bus_read(1'b0, 1'b0);
      end
      8: begin
        bus_read(1'b1, 1'($urandom));
      end
      default: begin
        repeat ($urandom_range(1, 4))
          put_req(kind_t'($urandom_range(KIND_TICK, KIND_CMD)),
                  cmd_t'($urandom_range(CMD_RESET, CMD_NONE)), 8'($urandom), 1'($urandom));
      end
    endcase
  endtask

  // main sequence
  initial begin
    int unsigned start;
    rst_n            = 1'b0;
    tx_gaps          = 1'b0;
    rx_gaps          = 1'b0;
    hold_req         = 1'b0;
    busy_noise       = 1'b0;
    accepted         = 0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = KIND_TICK;
    in_ch.command    = CMD_RESET;
    in_ch.write_data = '0;
    in_ch.line_level = 1'b1;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = REG_RESET_LOW;
    cfg_ch.wdata     = '0;
    timing[REG_RESET_LOW]   = RstResetLow;
    timing[REG_RECOVERY]    = RstRecovery;
    timing[REG_PRES_TMO]    = RstPresTmo;
    timing[REG_PRES_MAXLOW] = RstPresMaxLow;
    timing[REG_SHORT_LOW]   = RstShortLow;
    timing[REG_LONG_LOW]    = RstLongLow;
    timing[REG_SAMPLE_DLY]  = RstSampleDly;
    timing[REG_READ_TAIL]   = RstReadTail;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one read at the reset timings
    bus_read(1'b0, 1'b0);
    go_idle();

    // shortest timings: zero lengths, presence low too long on its first tick
    timing[REG_RESET_LOW]   = 10'd0;
    timing[REG_RECOVERY]    = 10'd0;
    timing[REG_PRES_TMO]    = 10'd1;
    timing[REG_PRES_MAXLOW] = 10'd1;
    timing[REG_SHORT_LOW]   = 10'd1;
    timing[REG_LONG_LOW]    = 10'd1;
    timing[REG_SAMPLE_DLY]  = 10'd0;
    timing[REG_READ_TAIL]   = 10'd0;
    load_timing();
    issue(CMD_NONE, 8'hFF);
    tick(1'b0);
    tick(1'b1);
    bus_reset(0, 1);
    bus_reset(1, 0);
    bus_write(8'h00);
    bus_write(8'hFF);
    bus_read(1'b1, 1'b1);
    bus_read(1'b1, 1'b0);
    // command while busy is dropped
    issue(CMD_WRITE, 8'h5A);
    issue(CMD_READ, 8'h00);
    run_ticks(20, 1'b0, 1'b0);
    go_idle();

    // small timings: presence ok, too long and missing
    timing[REG_RESET_LOW]   = 10'd2;
    timing[REG_RECOVERY]    = 10'd1;
    timing[REG_PRES_TMO]    = 10'd3;
    timing[REG_PRES_MAXLOW] = 10'd4;
    timing[REG_SHORT_LOW]   = 10'd1;
    timing[REG_LONG_LOW]    = 10'd3;
    timing[REG_SAMPLE_DLY]  = 10'd1;
    timing[REG_READ_TAIL]   = 10'd2;
    load_timing();
    bus_reset(1, 2);
    bus_reset(0, 6);
    bus_reset(5, 0);
    bus_write(8'hA5);
    bus_read(1'b0, 1'b0);
    go_idle();

    // long timings: wide reset pulse count, presence limits at the top
    foreach (timing[i]) timing[i] = '1;
    timing[REG_RESET_LOW] = 10'd520;
    timing[REG_RECOVERY]  = 10'd3;
    load_timing();
    bus_reset(2, 3);
    go_idle();

    // random phases, hold-off in one, no idling in the last
    busy_noise = 1'b1;
    tx_gaps    = 1'b1;
    rx_gaps    = 1'b1;
    for (int p = 0; p < 6; p++) begin
      if (p == 5) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end
      shuffle_timing();
      load_timing();
      if (p == 2) hold_req = 1'b1;
      start = accepted;
      while (accepted - start < PhaseBudget) random_op();
      go_idle();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_one_wire_bus_master: clean");
    end else begin
      $display("tb_one_wire_bus_master: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/owb_pkg.sv
hw/rtl/owb_req_if.sv
hw/rtl/owb_res_if.sv
hw/rtl/owb_cfg_if.sv
hw/rtl/owb_seq.sv
hw/rtl/one_wire_bus_master.sv
dv/owb_result_monitor.sv
dv/tb_one_wire_bus_master.sv
